[rtl/core/bpk_pkg.sv]
package bpk_pkg;

	// field widths fixed by the stream format
	localparam int CODE_FIELD_BITS   = 16;
	localparam int BPK_MAX_CODE_BITS = 16;
	localparam int ACC_BITS          = 23;
	localparam int QUEUE_DEPTH       = 2;

	// request codes
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_FLUSH = 2'd1,
		REQ_RAW   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [1:0]  nbytes;
		logic [15:0] data;
		logic        esc;
		logic [3:0]  free_bits;
		logic [2:0]  ones;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// run of ones at the bottom of the pending bits
	function automatic logic [2:0] count_trailing_ones(input logic [6:0] bits,
		input logic [2:0] cnt);
		logic [2:0] n;
		logic       run;
		n   = 3'd0;
		run = 1'b1;
		for (int i = 0; i < 7; i++) begin
			if (run && (3'(i) < cnt) && bits[i]) begin
				n = n + 3'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

[rtl/core/bpk_ifs.sv]
interface bpk_in_if;
	import bpk_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] code_bits;
	logic [4:0]  bit_count;
	logic        escape_enable;
	logic [15:0] raw_word;

	modport source (output valid, req_type, code_bits, bit_count, escape_enable, raw_word,
		input ready);
	modport sink (input valid, req_type, code_bits, bit_count, escape_enable, raw_word,
		output ready);
endinterface

interface bpk_out_if;
	import bpk_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       stuffed_zero;
	logic       last;
	logic [3:0] free_bits;
	logic [2:0] trailing_ones;

	modport source (output valid, out_byte, byte_valid, stuffed_zero, last, free_bits,
		trailing_ones, input ready);
	modport sink (input valid, out_byte, byte_valid, stuffed_zero, last, free_bits,
		trailing_ones, output ready);
endinterface

[rtl/core/bpk_front.sv]
module bpk_front #(
	parameter int MAX_CODE_BITS = bpk_pkg::BPK_MAX_CODE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	bpk_in_if.sink             req,
	input  bpk_pkg::q_status_t qs,
	output logic               push,
	output bpk_pkg::job_t      job
);
	import bpk_pkg::*;

	localparam int CODE_LIMIT = (MAX_CODE_BITS < CODE_FIELD_BITS) ? MAX_CODE_BITS
		: CODE_FIELD_BITS;

	logic [6:0]          pend_q;
	logic [2:0]          pcnt_q;
	logic [4:0]          n_sat;
	logic [4:0]          n_eff;
	logic [15:0]         code_eff;
	logic [ACC_BITS-1:0] acc;
	logic [ACC_BITS-1:0] acc_sh;
	logic [4:0]          total;
	logic [2:0]          rem;
	logic [6:0]          pend_d;
	logic [2:0]          pcnt_d;

	assign req.ready = !qs.full;
	assign push      = req.valid && !qs.full;

	// saturate the code length
	assign n_sat = (req.bit_count > 5'(CODE_LIMIT)) ? 5'(CODE_LIMIT) : req.bit_count;

	// pick the bits to append for each request kind
	always_comb begin
		n_eff    = 5'd0;
		code_eff = 16'd0;
		unique case (req_t'(req.req_type))
			REQ_WRITE: begin
				n_eff    = n_sat;
				code_eff = req.code_bits;
			end
			REQ_FLUSH: begin
				n_eff = (pcnt_q == 3'd0) ? 5'd0 : 5'd8 - {2'b00, pcnt_q};
			end
			REQ_RAW, REQ_NONE: begin
				n_eff = 5'd0;
			end
		endcase
	end

	// append and split into whole bytes and the new pending bits
	always_comb begin
		acc    = ({16'd0, pend_q} << n_eff)
			| ({7'd0, code_eff} & ~({ACC_BITS{1'b1}} << n_eff));
		total  = {2'b00, pcnt_q} + n_eff;
		rem    = total[2:0];
		acc_sh = acc >> rem;
		pend_d = acc[6:0] & ~(7'h7F << rem);
		pcnt_d = rem;
	end

	// classified item for the back end
	always_comb begin
		job.esc = 1'b0;
		if (req_t'(req.req_type) == REQ_RAW) begin
			job.nbytes    = 2'd2;
			job.data      = req.raw_word;
			job.free_bits = 4'd8 - {1'b0, pcnt_q};
			job.ones      = count_trailing_ones(pend_q, pcnt_q);
		end else begin
			job.nbytes    = total[4:3];
			job.data      = (total[4:3] == 2'd1) ? {acc_sh[7:0], 8'h00} : acc_sh[15:0];
			job.esc       = (req_t'(req.req_type) == REQ_WRITE) && req.escape_enable;
			job.free_bits = 4'd8 - {1'b0, pcnt_d};
			job.ones      = count_trailing_ones(pend_d, pcnt_d);
		end
	end

	// pending bit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 7'd0;
			pcnt_q <= 3'd0;
		end else if (push && (req_t'(req.req_type) != REQ_RAW)) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

endmodule

[rtl/core/bpk_fifo.sv]
module bpk_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bpk_pkg::job_t      wr_job,
	input  logic               pop,
	output bpk_pkg::job_t      head,
	output bpk_pkg::q_status_t qs
);
	import bpk_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign qs.full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign qs.empty = (cnt_q == '0);
	assign head     = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

[rtl/core/bpk_back.sv]
module bpk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bpk_pkg::job_t      head,
	input  bpk_pkg::q_status_t qs,
	output logic               pop,
	bpk_out_if.source          res
);
	import bpk_pkg::*;

	logic       idx_q;
	logic       stuff_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       stuffed_q;
	logic       last_q;
	logic [3:0] free_q;
	logic [2:0] ones_q;

	logic [7:0] cur;
	logic       status_only;
	logic       need_stuff;
	logic       final_res;
	logic       fire;

	// current byte and what follows it
	always_comb begin
		cur         = idx_q ? head.data[7:0] : head.data[15:8];
		status_only = (head.nbytes == 2'd0);
		need_stuff  = !status_only && !stuff_q && head.esc && (cur == 8'hFF);
		final_res   = status_only || (!need_stuff && (idx_q == (head.nbytes == 2'd2)));
		fire        = !qs.empty && (!ov_q || res.ready);
		pop         = fire && final_res;
	end

	// byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 1'b0;
			stuff_q <= 1'b0;
		end else if (fire) begin
			priority if (final_res) begin
				idx_q   <= 1'b0;
				stuff_q <= 1'b0;
			end else if (need_stuff) begin
				stuff_q <= 1'b1;
			end else begin
				stuff_q <= 1'b0;
				idx_q   <= 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fire) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q    <= (status_only || stuff_q) ? 8'h00 : cur;
			bvalid_q  <= !status_only;
			stuffed_q <= stuff_q && !status_only;
			last_q    <= final_res;
			free_q    <= head.free_bits;
			ones_q    <= head.ones;
		end
	end

	assign res.valid         = ov_q;
	assign res.out_byte      = byte_q;
	assign res.byte_valid    = bvalid_q;
	assign res.stuffed_zero  = stuffed_q;
	assign res.last          = last_q;
	assign res.free_bits     = free_q;
	assign res.trailing_ones = ones_q;

endmodule

[rtl/core/jpeg_bit_packer_with_stuffing.sv]
// channel  dir  payload                                                  accepted when
// req      in   req_type code_bits bit_count escape_enable raw_word      valid && ready
// res      out  out_byte byte_valid stuffed_zero last free_bits          valid && ready
//               trailing_ones
//
// the front takes one item per cycle while the two-entry queue has room
// the back sends one result per cycle while res is not stalled: one to four results per item
// an item that is taken is written into the queue and from there into the output register
// a stall on res fills the queue and then drops req.ready
// arst_n clears the pending bits, the queue and the output valid
module jpeg_bit_packer_with_stuffing #(
	parameter int MAX_CODE_BITS = bpk_pkg::BPK_MAX_CODE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	bpk_in_if.sink     req,
	bpk_out_if.source  res
);
	import bpk_pkg::*;

	job_t      push_job;
	job_t      head;
	q_status_t qs;
	logic      push;
	logic      pop;

	bpk_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.qs    (qs),
		.push  (push),
		.job   (push_job)
	);

	bpk_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(push_job),
		.pop   (pop),
		.head  (head),
		.qs    (qs)
	);

	bpk_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.qs    (qs),
		.pop   (pop),
		.res   (res)
	);

endmodule

[rtl/core/bpk_checker.sv]
module bpk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       stuffed_zero,
	input logic       last,
	input logic [3:0] free_bits,
	input logic [2:0] trailing_ones
);

	// a result waits until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// pending status stays consistent
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (free_bits >= 4'd1) && (free_bits <= 4'd8)
			&& ({1'b0, trailing_ones} <= 4'd8 - free_bits))
		else $error("free bits and trailing ones disagree");

	// a stuffed zero is a real zero byte
	a_stuff: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && stuffed_zero |-> byte_valid && (out_byte == 8'h00))
		else $error("bad stuffing byte");

	// a status-only result closes its item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !byte_valid |-> last && !stuffed_zero && (out_byte == 8'h00))
		else $error("bad status-only result");

endmodule

bind jpeg_bit_packer_with_stuffing bpk_checker u_bpk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.out_byte     (res.out_byte),
	.byte_valid   (res.byte_valid),
	.stuffed_zero (res.stuffed_zero),
	.last         (res.last),
	.free_bits    (res.free_bits),
	.trailing_ones(res.trailing_ones)
);
